FILE: hdl/bmhq_pkg.sv
// Shared types and sizing for the binary max-heap queue.
// Used by the controller, the datapath and the top level.
package bmhq_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_W     = 32;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int CHILD_W   = ADDR_W + 2;
   localparam int OUT_CNT_W = 7;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                    kind;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [KEY_W-1:0] top_key;
      logic                    has_top;
      logic [OUT_CNT_W-1:0]    entry_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic up_read;
      logic up_move;
      logic up_place;
      logic dn_last_read;
      logic dn_start;
      logic dn_move;
      logic dn_place;
      logic rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic up_greater;
      logic dn_greater;
      logic rsp_free;
   } stat_type;

endpackage

FILE: hdl/binary_max_heap_queue.sv
// Max-priority queue of signed 32-bit keys held as a binary heap in a
// 64-entry two-read-port RAM. Each accepted item (insert or delete-max)
// yields one result with status, entry count and the largest key. An insert
// into a full heap or a delete on an empty heap goes straight to the result.
// Otherwise an insert climbs L levels (0..6) toward the root, and a delete
// reads the last entry and, unless the heap has just become empty, moves it
// to the root and sifts it down L levels (0..5). Every level costs one RAM
// read state and one compare/write state, in that order. One item is in
// work at a time; a finished result sits in an output register so the next
// item can be accepted while it waits, and that next result is held back
// while the previous one is still stalled.
// Depends on bmhq_pkg, bmhq_ctrl, bmhq_dpath and bmhq_ram.
module binary_max_heap_queue
   import bmhq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   bmhq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_kind (req_data.kind),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   bmhq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

FILE: hdl/bmhq_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

FILE: hdl/bmhq_ctrl.sv
// Sequencer for the heap queue: accept, sift up or down, respond.
// Depends on bmhq_pkg.
module bmhq_ctrl
   import bmhq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_kind,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_UP_RD    = 3'd1;
   localparam logic [2:0] ST_UP_CMP   = 3'd2;
   localparam logic [2:0] ST_DN_LAST  = 3'd3;
   localparam logic [2:0] ST_DN_START = 3'd4;
   localparam logic [2:0] ST_DN_RD    = 3'd5;
   localparam logic [2:0] ST_DN_CMP   = 3'd6;
   localparam logic [2:0] ST_RESP     = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_kind == KIND_INSERT) begin
                  state_in = stat.full ? ST_RESP : ST_UP_RD;
               end else begin
                  state_in = stat.empty ? ST_RESP : ST_DN_LAST;
               end
            end
         end
         ST_UP_RD: begin
            if (stat.pos_zero) begin
               cmd.up_place = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.up_read = 1'b1;
               state_in    = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (stat.up_greater) begin
               cmd.up_move = 1'b1;
               state_in    = ST_UP_RD;
            end else begin
               cmd.up_place = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_DN_LAST: begin
            cmd.dn_last_read = 1'b1;
            state_in         = ST_DN_START;
         end
         ST_DN_START: begin
            // heap just became empty: nothing to move
            if (stat.empty) begin
               state_in = ST_RESP;
            end else begin
               cmd.dn_start = 1'b1;
               state_in     = ST_DN_RD;
            end
         end
         ST_DN_RD: begin
            // both children are read from the current position
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (stat.dn_greater) begin
               cmd.dn_move = 1'b1;
               state_in    = ST_DN_RD;
            end else begin
               cmd.dn_place = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> state_ff == ST_IDLE)
      else $error("accept outside idle");

   a_resp_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> state_ff == ST_IDLE)
      else $error("no return to idle after response");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.up_move, cmd.up_place, cmd.dn_move, cmd.dn_place}) <= 1)
      else $error("more than one memory write command");

endmodule

FILE: hdl/bmhq_dpath.sv
// Datapath: heap memory, fill count, sift position and key, result register.
// Depends on bmhq_pkg and bmhq_ram.
module bmhq_dpath
   import bmhq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]       pos_ff, pos_in;
   logic signed [KEY_W-1:0] cur_ff, cur_in;
   logic signed [KEY_W-1:0] top_ff;
   logic [1:0]              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff;

   logic                    wr_en;
   logic [ADDR_W-1:0]       rd_a_addr, rd_b_addr, parent;
   logic signed [KEY_W-1:0] wr_data, rd_a_data, rd_b_data;
   logic [CHILD_W-1:0]      left_idx, right_idx, count_ext;
   logic                    left_ok, right_ok, take_left, take_right;
   logic signed [KEY_W-1:0] best_val, dn_next_val;
   logic [ADDR_W-1:0]       dn_next_pos;

   assign parent    = ADDR_W'((pos_ff - 1'b1) >> 1);
   assign left_idx  = {1'b0, pos_ff, 1'b1};
   assign right_idx = left_idx + 1'b1;
   assign count_ext = CHILD_W'(count_ff);

   assign left_ok     = left_idx < count_ext;
   assign right_ok    = right_idx < count_ext;
   assign take_left   = left_ok && (rd_a_data > cur_ff);
   assign best_val    = take_left ? rd_a_data : cur_ff;
   assign take_right  = right_ok && (rd_b_data > best_val);
   assign dn_next_val = take_right ? rd_b_data : rd_a_data;
   assign dn_next_pos = take_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

   always_comb begin
      if (cmd.up_read) begin
         rd_a_addr = parent;
      end else if (cmd.dn_last_read) begin
         rd_a_addr = count_ff[ADDR_W-1:0];
      end else begin
         rd_a_addr = left_idx[ADDR_W-1:0];
      end
   end
   assign rd_b_addr = right_idx[ADDR_W-1:0];

   // the sifted key stays in cur_ff; entries it passes move one level
   assign wr_en   = cmd.up_move | cmd.up_place | cmd.dn_move | cmd.dn_place;
   assign wr_data = cmd.up_move ? rd_a_data :
                    cmd.dn_move ? dn_next_val : cur_ff;

   bmhq_ram #(
      .WIDTH(KEY_W),
      .DEPTH(CAPACITY)
   ) u_heap (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (pos_ff),
      .wr_data  (wr_data),
      .rd_a_addr(rd_a_addr),
      .rd_a_data(rd_a_data),
      .rd_b_addr(rd_b_addr),
      .rd_b_data(rd_b_data)
   );

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      status_in = status_ff;
      if (cmd.accept) begin
         status_in = STATUS_DONE;
         if (req_data.kind == KIND_INSERT) begin
            if (stat.full) begin
               status_in = STATUS_FULL;
            end else begin
               pos_in   = count_ff[ADDR_W-1:0];
               cur_in   = req_data.key;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (stat.empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
      end
      if (cmd.up_move) begin
         pos_in = parent;
      end
      if (cmd.dn_start) begin
         cur_in = rd_a_data;
         pos_in = '0;
      end
      if (cmd.dn_move) begin
         pos_in = dn_next_pos;
      end
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      // shadow of the root entry
      if (wr_en && pos_ff == '0) begin
         top_ff <= wr_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.has_top     <= (count_ff != '0);
         rsp_ff.top_key     <= (count_ff != '0) ? top_ff : '0;
         rsp_ff.entry_count <= OUT_CNT_W'(count_ff);
      end
   end

   assign stat.full       = (count_ff == CNT_W'(CAPACITY));
   assign stat.empty      = (count_ff == '0);
   assign stat.pos_zero   = (pos_ff == '0);
   assign stat.up_greater = (cur_ff > rd_a_data);
   assign stat.dn_greater = take_left | take_right;
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && req_data.kind == KIND_INSERT && !stat.full
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the heap");

   a_dn_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.dn_move |-> CHILD_W'(dn_next_pos) < count_ext)
      else $error("sift down moved past the last entry");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a pending item");

endmodule

FILE: test/tb_binary_max_heap_queue.sv
// Self-checking testbench for binary_max_heap_queue: directed table, then phased random
// insert/delete traffic, results checked against typed rows or an in-bench heap predictor.
// Depends on bmhq_pkg and the binary_max_heap_queue RTL.
`timescale 1ns / 1ps

module tb_binary_max_heap_queue;
   import bmhq_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } step_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // predictor state
   logic signed [KEY_W-1:0] heap_keys [CAPACITY];
   int                      heap_fill = 0;

   rsp_type      pending_results [$];
   step_row_type script [$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   bit           no_idle = 1'b0;
   int           rsp_hold = 0;

   binary_max_heap_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Apply one item to the predictor heap and return the result it produces.
   function automatic rsp_type heap_apply(input req_type item);
      rsp_type                 r;
      int                      pos;
      int                      best;
      int                      lc;
      int                      rc;
      bit                      settled;
      logic signed [KEY_W-1:0] tmp;
      r.status = STATUS_DONE;
      if (item.kind == KIND_INSERT) begin
         if (heap_fill >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            pos = heap_fill;
            heap_keys[pos] = item.key;
            heap_fill++;
            // climb only while strictly larger than the parent
            while (pos > 0 && heap_keys[pos] > heap_keys[(pos - 1) / 2]) begin
               tmp = heap_keys[pos];
               heap_keys[pos] = heap_keys[(pos - 1) / 2];
               heap_keys[(pos - 1) / 2] = tmp;
               pos = (pos - 1) / 2;
            end
         end
      end else begin
         if (heap_fill == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            heap_fill--;
            heap_keys[0] = heap_keys[heap_fill];
            pos = 0;
            settled = 1'b0;
            while (!settled) begin
               lc = 2 * pos + 1;
               rc = 2 * pos + 2;
               best = pos;
               // left child wins a tie between children
               if (lc < heap_fill && heap_keys[lc] > heap_keys[best]) best = lc;
               if (rc < heap_fill && heap_keys[rc] > heap_keys[best]) best = rc;
               if (best == pos) begin
                  settled = 1'b1;
               end else begin
                  tmp = heap_keys[pos];
                  heap_keys[pos] = heap_keys[best];
                  heap_keys[best] = tmp;
                  pos = best;
               end
            end
         end
      end
      r.has_top     = (heap_fill > 0);
      r.top_key     = (heap_fill > 0) ? heap_keys[0] : '0;
      r.entry_count = heap_fill[OUT_CNT_W-1:0];
      return r;
   endfunction

   function automatic void add_row(input logic kind, input logic signed [KEY_W-1:0] key,
                                   input bit typed, input logic [1:0] status,
                                   input logic signed [KEY_W-1:0] top, input logic has,
                                   input logic [OUT_CNT_W-1:0] count);
      step_row_type row;
      row.item.kind         = kind;
      row.item.key          = key;
      row.typed             = typed;
      row.want.status       = status;
      row.want.top_key      = top;
      row.want.has_top      = has;
      row.want.entry_count  = count;
      script = {script, row};
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_op(input req_type item, input bit typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predicted = heap_apply(item);
      pending_results = {pending_results, (typed ? want : predicted)};
      @(negedge clock);
   endtask

   // result side: draw a stall length per item
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_type want;
         rsp_hold = no_idle ? 0 : $urandom_range(0, 4);
         if (pending_results.size() == 0) begin
            flag_mismatch("result with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status)
               flag_mismatch($sformatf("status got %0d want %0d",
                                       rsp_data.status, want.status));
            if (rsp_data.top_key !== want.top_key)
               flag_mismatch($sformatf("top_key got %0d want %0d",
                                       rsp_data.top_key, want.top_key));
            if (rsp_data.has_top !== want.has_top)
               flag_mismatch($sformatf("has_top got %0d want %0d",
                                       rsp_data.has_top, want.has_top));
            if (rsp_data.entry_count !== want.entry_count)
               flag_mismatch($sformatf("entry_count got %0d want %0d",
                                       rsp_data.entry_count, want.entry_count));
         end
      end
   end

   initial begin : stimulus
      localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
      localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
      req_type                 item;
      logic signed [KEY_W-1:0] last_key;
      int                      sent;
      int                      phase_len;
      int                      insert_pct;
      int                      mode;

      // empty heap, extremes, ties at the top, then drain past empty
      add_row(KIND_DELETE, 32'sd0, 1, STATUS_EMPTY, 32'sd0, 1'b0, 7'd0);
      add_row(KIND_DELETE, KEY_MAX, 1, STATUS_EMPTY, 32'sd0, 1'b0, 7'd0);
      add_row(KIND_INSERT, KEY_MIN, 1, STATUS_DONE, KEY_MIN, 1'b1, 7'd1);
      add_row(KIND_DELETE, KEY_MIN, 1, STATUS_DONE, 32'sd0, 1'b0, 7'd0);
      add_row(KIND_INSERT, KEY_MIN, 1, STATUS_DONE, KEY_MIN, 1'b1, 7'd1);
      add_row(KIND_INSERT, KEY_MAX, 1, STATUS_DONE, KEY_MAX, 1'b1, 7'd2);
      add_row(KIND_INSERT, 32'sd0, 0, '0, '0, 1'b0, '0);
      add_row(KIND_INSERT, -32'sd1, 0, '0, '0, 1'b0, '0);
      add_row(KIND_INSERT, 32'sd1, 0, '0, '0, 1'b0, '0);
      add_row(KIND_INSERT, KEY_MAX, 0, '0, '0, 1'b0, '0);
      add_row(KIND_INSERT, KEY_MAX, 0, '0, '0, 1'b0, '0);
      add_row(KIND_INSERT, -32'sd5, 0, '0, '0, 1'b0, '0);
      add_row(KIND_INSERT, 32'sd100, 0, '0, '0, 1'b0, '0);
      repeat (8) add_row(KIND_DELETE, 32'sh5555_AAAA, 0, '0, '0, 1'b0, '0);
      add_row(KIND_DELETE, 32'sd0, 1, STATUS_DONE, 32'sd0, 1'b0, 7'd0);
      add_row(KIND_DELETE, -32'sd1, 1, STATUS_EMPTY, 32'sd0, 1'b0, 7'd0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_op(script[i].item, script[i].typed, script[i].want);

      // phases cycle through filling (reaches full), draining (reaches empty), mixed
      sent = 0;
      mode = 0;
      last_key = 32'sd0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(100, 160);
         no_idle = ($urandom_range(0, 3) == 0);
         case (mode)
            0: insert_pct = 90;
            1: insert_pct = 12;
            default: insert_pct = 50;
         endcase
         for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
            item.kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
            case ($urandom_range(0, 9)) inside
               0: item.key = KEY_MIN;
               1: item.key = KEY_MAX;
               [2:3]: item.key = $signed($urandom_range(0, 8)) - 32'sd4;
               4: item.key = last_key;
               default: item.key = $urandom;
            endcase
            last_key = item.key;
            send_op(item, 1'b0, '0);
            sent++;
         end
         mode = (mode + 1) % 3;
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
